// ===== rtl/core/vac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vac_pkg
// Shared types and constants for the vsync-locked animation clock.
// ----------------------------------------------------------------------------
package vac_pkg;

  localparam int unsigned WallW   = 40;
  localparam int unsigned ClkW    = 41;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned ThreshW = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 20;

  localparam logic [CfgIdxW-1:0] RegVsyncPeriod  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBadMargin    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHardThresh   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSoftWindow   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCatchupStep  = 3'd4;

  localparam logic KindStart = 1'b0;
  localparam logic KindFrame = 1'b1;

  localparam logic ModePredicted = 1'b0;
  localparam logic ModeCurrent   = 1'b1;

  typedef struct packed {
    logic [PeriodW-1:0] vsync_period;
    logic [PeriodW-1:0] bad_margin;
    logic [ThreshW-1:0] hard_threshold;
    logic [ThreshW-1:0] soft_window;
    logic [PeriodW-1:0] catchup_step;
  } cfg_t;

  typedef struct packed {
    logic [ClkW-1:0]  anim_clock;
    logic             mode_flag;
    logic [WallW-1:0] last_bad_time;
  } state_t;

endpackage

// ===== rtl/core/vac_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vac_step
// Next-state logic of the animation clock for one start or frame transaction.
// ----------------------------------------------------------------------------
module vac_step (
  input  vac_pkg::cfg_t                   cfg_i,
  input  vac_pkg::state_t                 state_i,
  input  logic                            kind_i,
  input  logic [vac_pkg::WallW-1:0]       wall_i,
  output vac_pkg::state_t                 state_o,
  output logic                            bad_o
);

  logic [vac_pkg::ClkW:0]         sum_period;
  logic [vac_pkg::ClkW-1:0]       clk_adv;
  logic [vac_pkg::ClkW:0]         sum_catch;
  logic [vac_pkg::ClkW-1:0]       clk_up;
  logic [vac_pkg::ClkW-1:0]       clk_dn;
  logic [vac_pkg::ClkW-1:0]       catch_ext;
  logic signed [vac_pkg::ClkW+1:0] drift;
  logic signed [vac_pkg::ClkW+1:0] neg_two_period;
  logic signed [vac_pkg::WallW:0]  since_bad;
  logic signed [vac_pkg::WallW:0]  soft_ext;
  logic                            bad;
  logic                            have_bad;
  logic                            hard;

  assign catch_ext  = {{(vac_pkg::ClkW - vac_pkg::PeriodW){1'b0}}, cfg_i.catchup_step};
  assign sum_period = {1'b0, state_i.anim_clock}
                    + {{(vac_pkg::ClkW + 1 - vac_pkg::PeriodW){1'b0}}, cfg_i.vsync_period};
  assign clk_adv    = sum_period[vac_pkg::ClkW] ? '1 : sum_period[vac_pkg::ClkW-1:0];
  assign sum_catch  = {1'b0, clk_adv} + {1'b0, catch_ext};
  assign clk_up     = sum_catch[vac_pkg::ClkW] ? '1 : sum_catch[vac_pkg::ClkW-1:0];
  assign clk_dn     = (clk_adv > catch_ext) ? (clk_adv - catch_ext) : '0;

  assign drift = $signed({3'b000, wall_i}) - $signed({2'b00, clk_adv});
  assign neg_two_period = -$signed({{(vac_pkg::ClkW + 1 - vac_pkg::PeriodW){1'b0}},
                                    cfg_i.vsync_period, 1'b0});
  assign since_bad = $signed({1'b0, wall_i}) - $signed({1'b0, state_i.last_bad_time});
  assign soft_ext  = $signed({{(vac_pkg::WallW + 1 - vac_pkg::ThreshW){1'b0}},
                              cfg_i.soft_window});

  assign bad = drift > $signed({{(vac_pkg::ClkW + 2 - vac_pkg::PeriodW){1'b0}},
                                cfg_i.bad_margin});
  assign hard = drift > $signed({{(vac_pkg::ClkW + 2 - vac_pkg::ThreshW){1'b0}},
                                 cfg_i.hard_threshold});
  assign have_bad = state_i.last_bad_time != '0;

  always_comb begin
    state_o = state_i;
    bad_o   = 1'b0;
    if (kind_i == vac_pkg::KindStart) begin
      state_o.anim_clock    = '0;
      state_o.last_bad_time = '0;
    end else if (cfg_i.vsync_period == '0) begin
      state_o.anim_clock = {1'b0, wall_i};
    end else begin
      bad_o              = bad;
      state_o.anim_clock = clk_adv;
      if (hard) begin
        state_o.mode_flag  = vac_pkg::ModeCurrent;
        state_o.anim_clock = {1'b0, wall_i};
      end else if (state_i.mode_flag == vac_pkg::ModePredicted) begin
        if (bad) begin
          if (have_bad && (since_bad < soft_ext)) begin
            state_o.mode_flag  = vac_pkg::ModeCurrent;
            state_o.anim_clock = {1'b0, wall_i};
          end
          state_o.last_bad_time = wall_i;
        end else if (drift > $signed({2'b00, catch_ext})) begin
          state_o.anim_clock = clk_up;
        end else if (drift < neg_two_period) begin
          state_o.anim_clock = clk_dn;
        end
      end else begin
        if (bad) begin
          state_o.last_bad_time = wall_i;
        end else if (have_bad && (since_bad > soft_ext)) begin
          state_o.mode_flag = vac_pkg::ModePredicted;
        end
        state_o.anim_clock = {1'b0, wall_i};
      end
    end
  end

endmodule

// ===== rtl/core/vsync_animation_clock.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsync_animation_clock
// Animation clock locked to vsync, with predicted and wall-time modes.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tuser: kind; tdata: wall_time[39:0]
//  m_axis    out        tdata: anim_time[40:0]; tuser: time_mode, bad_frame
//  cfg       in         write enable, register index, 20-bit data
//
//  One transaction per cycle while the result is not stalled; the input
//  register and the result register sit around the combinational clock
//  update.
//  Reset clears the clock state and loads the default registers.
//  A stalled result holds; the input side keeps accepting while the
//  result register can be refilled in the same cycle.
// ----------------------------------------------------------------------------
module vsync_animation_clock (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [39:0]                  s_axis_tdata,   // wall_time
  input  logic                         s_axis_tuser,   // kind
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [47:0]                  m_axis_tdata,   // anim_time, zero pad
  output logic [1:0]                   m_axis_tuser,   // time_mode, bad_frame
  input  logic                         cfg_we_i,
  input  logic [vac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vac_pkg::CfgDatW-1:0]  cfg_wdata_i
);

  vac_pkg::cfg_t                 cfg_q;
  vac_pkg::state_t               state_q;
  vac_pkg::state_t               state_d;
  logic                          in_valid_q;
  logic                          kind_q;
  logic [vac_pkg::WallW-1:0]     wall_q;
  logic                          out_valid_q;
  logic [vac_pkg::ClkW-1:0]      anim_q;
  logic                          mode_q;
  logic                          bad_q;
  logic                          bad_d;
  logic                          out_free;
  logic                          fire;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vsync_period   <= 16'd4267;
      cfg_q.bad_margin     <= 16'd427;
      cfg_q.hard_threshold <= 20'd25600;
      cfg_q.soft_window    <= 20'd25600;
      cfg_q.catchup_step   <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vac_pkg::RegVsyncPeriod: cfg_q.vsync_period   <= cfg_wdata_i[15:0];
        vac_pkg::RegBadMargin:   cfg_q.bad_margin     <= cfg_wdata_i[15:0];
        vac_pkg::RegHardThresh:  cfg_q.hard_threshold <= cfg_wdata_i;
        vac_pkg::RegSoftWindow:  cfg_q.soft_window    <= cfg_wdata_i;
        vac_pkg::RegCatchupStep: cfg_q.catchup_step   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q <= s_axis_tuser;
      wall_q <= s_axis_tdata;
    end
  end

  vac_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .kind_i  (kind_q),
    .wall_i  (wall_q),
    .state_o (state_d),
    .bad_o   (bad_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      anim_q <= state_d.anim_clock;
      mode_q <= state_d.mode_flag;
      bad_q  <= bad_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, anim_q};
  assign m_axis_tuser  = {bad_q, mode_q};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vsync-locked animation clock. Start and frame
// transactions go in on the input stream. A local prediction of the clock,
// the mode and the bad-frame flag is queued per transaction and checked
// against each output transaction. Traffic covers directed corner cases,
// random animation runs under several register settings, random idling on
// both streams, a long output stall and back-to-back traffic.
// ----------------------------------------------------------------------------
module tb_top;

  localparam longint ClockMax   = (64'sd1 <<< vac_pkg::ClkW) - 1;
  localparam int     CycleLimit = 300000;
  localparam int     HoldCycles = 300;

  typedef struct packed {
    logic [vac_pkg::ClkW-1:0] anim_time;
    logic                     time_mode;
    logic                     bad_frame;
  } anim_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [39:0]                  s_axis_tdata;   // wall_time[39:0]
  logic                         s_axis_tuser;   // kind
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [47:0]                  m_axis_tdata;   // anim_time[40:0], zero pad
  logic [1:0]                   m_axis_tuser;   // time_mode, bad_frame
  logic                         cfg_we_i;
  logic [vac_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [vac_pkg::CfgDatW-1:0]  cfg_wdata_i;

  // register shadow
  logic [vac_pkg::PeriodW-1:0]  period_q;
  logic [vac_pkg::PeriodW-1:0]  margin_q;
  logic [vac_pkg::ThreshW-1:0]  hard_q;
  logic [vac_pkg::ThreshW-1:0]  window_q;
  logic [vac_pkg::PeriodW-1:0]  step_q;

  // clock state shadow
  logic [vac_pkg::ClkW-1:0]     clock_q;
  logic                         mode_q;
  logic [vac_pkg::WallW-1:0]    last_bad_q;

  anim_result_t        anim_results_q[$];
  int                  error_cnt;
  int                  cycle_cnt;
  bit                  tx_idle;
  bit                  rx_idle;
  bit                  hold_req;

  vsync_animation_clock DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic longint clamp_clock(longint v);
    if (v > ClockMax) return ClockMax;
    if (v < 0) return 0;
    return v;
  endfunction

  function automatic anim_result_t predict_anim_time(logic kind,
                                                     logic [vac_pkg::WallW-1:0] wall);
    longint       now, clk, lbt, drift, since_bad, per, step;
    logic         bad_f, have_bad;
    anim_result_t res;
    now   = longint'(wall);
    clk   = longint'(clock_q);
    lbt   = longint'(last_bad_q);
    per   = longint'(period_q);
    step  = longint'(step_q);
    bad_f = 1'b0;
    if (kind == vac_pkg::KindStart) begin
      clk = 0;
      lbt = 0;
    end else if (per == 0) begin
      clk = now;
    end else begin
      since_bad = now - lbt;
      have_bad  = (lbt > 0);
      clk       = clamp_clock(clk + per);
      drift     = now - clk;
      bad_f     = (drift > longint'(margin_q));
      if (drift > longint'(hard_q)) begin
        mode_q = vac_pkg::ModeCurrent;
        clk    = now;
      end else if (mode_q == vac_pkg::ModePredicted) begin
        if (bad_f) begin
          if (have_bad && since_bad < longint'(window_q)) begin
            mode_q = vac_pkg::ModeCurrent;
            clk    = now;
          end
          lbt = now;
        end else if (drift > step) begin
          clk = clamp_clock(clk + step);
        end else if (drift < -2 * per) begin
          clk = clamp_clock(clk - step);
        end
      end else begin
        if (bad_f) begin
          lbt = now;
        end else if (have_bad && since_bad > longint'(window_q)) begin
          mode_q = vac_pkg::ModePredicted;
        end
        clk = now;
      end
    end
    clock_q       = clk[vac_pkg::ClkW-1:0];
    last_bad_q    = lbt[vac_pkg::WallW-1:0];
    res.anim_time = clock_q;
    res.time_mode = mode_q;
    res.bad_frame = bad_f;
    return res;
  endfunction

  function automatic logic [vac_pkg::WallW-1:0] rand_wall();
    logic [vac_pkg::WallW-1:0] w;
    w = vac_pkg::WallW'({$urandom, $urandom});
    return w;
  endfunction

  // leaves tvalid high on return; the caller drops it
  task automatic send_item(logic kind, logic [vac_pkg::WallW-1:0] wall);
    int gap;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= wall;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    anim_results_q.push_back(predict_anim_time(kind, wall));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (anim_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(logic [vac_pkg::PeriodW-1:0] per,
                          logic [vac_pkg::PeriodW-1:0] mar,
                          logic [vac_pkg::ThreshW-1:0] hrd,
                          logic [vac_pkg::ThreshW-1:0] win,
                          logic [vac_pkg::PeriodW-1:0] stp);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= vac_pkg::RegVsyncPeriod;
    cfg_wdata_i <= vac_pkg::CfgDatW'(per);
    @(posedge clk_i);
    cfg_idx_i   <= vac_pkg::RegBadMargin;
    cfg_wdata_i <= vac_pkg::CfgDatW'(mar);
    @(posedge clk_i);
    cfg_idx_i   <= vac_pkg::RegHardThresh;
    cfg_wdata_i <= vac_pkg::CfgDatW'(hrd);
    @(posedge clk_i);
    cfg_idx_i   <= vac_pkg::RegSoftWindow;
    cfg_wdata_i <= vac_pkg::CfgDatW'(win);
    @(posedge clk_i);
    cfg_idx_i   <= vac_pkg::RegCatchupStep;
    cfg_wdata_i <= vac_pkg::CfgDatW'(stp);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    period_q = per;
    margin_q = mar;
    hard_q   = hrd;
    window_q = win;
    step_q   = stp;
  endtask

  // animation runs: start, then frames near the vsync grid with jitter,
  // late frames, hard drops, repeats and long gaps, plus some noise
  task automatic random_traffic(int n);
    longint wall, per, mar, inc;
    int     pick;
    wall = 0;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      per  = (period_q == 0) ? 4000 : longint'(period_q);
      mar  = longint'(margin_q);
      if (pick < 6) begin
        wall = ($urandom_range(0, 4) == 0) ? longint'(rand_wall()) : 0;
        send_item(vac_pkg::KindStart, rand_wall());
      end else if (pick < 13) begin
        send_item(logic'($urandom_range(0, 1)), rand_wall());
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) inc = per + longint'($urandom_range(0, 2 * mar)) - mar;
        else if (pick < 78) inc = per + mar + 1 + longint'($urandom_range(0, per));
        else if (pick < 86) inc = per + longint'(hard_q) + 1 + longint'($urandom_range(0, 1000));
        else if (pick < 93) inc = 0;
        else inc = per * longint'($urandom_range(2, 40));
        wall = wall + inc;
        if (wall < 0) wall = 0;
        if (wall > longint'({vac_pkg::WallW{1'b1}})) wall = longint'({vac_pkg::WallW{1'b1}});
        send_item(vac_pkg::KindFrame, wall[vac_pkg::WallW-1:0]);
      end
    end
  endtask

  task automatic test_directed();
    send_item(vac_pkg::KindStart, {vac_pkg::WallW{1'b1}});
    send_item(vac_pkg::KindFrame, 40'd4267);
    send_item(vac_pkg::KindFrame, 40'd8834);
    send_item(vac_pkg::KindFrame, 40'd15000);
    send_item(vac_pkg::KindFrame, 40'd17400);
    send_item(vac_pkg::KindFrame, 40'd23000);
    send_item(vac_pkg::KindFrame, 40'd23100);
    send_item(vac_pkg::KindFrame, 40'd60000);
    send_item(vac_pkg::KindFrame, 40'd64267);
    send_item(vac_pkg::KindFrame, 40'd0);
    // unknown period follows the wall time
    set_regs(16'd0, 16'd427, 20'd25600, 20'd25600, 16'd256);
    send_item(vac_pkg::KindFrame, 40'h55_5555_5555);
    send_item(vac_pkg::KindFrame, 40'd1000);
    // clock saturates at zero when pulled back
    set_regs(16'd1, 16'd427, 20'd25600, 20'd25600, 16'hFFFF);
    send_item(vac_pkg::KindFrame, 40'd0);
    set_regs(16'd4267, 16'd427, 20'd25600, 20'd25600, 16'd256);
    send_item(vac_pkg::KindFrame, {vac_pkg::WallW{1'b1}});
    send_item(vac_pkg::KindStart, 40'd0);
    send_item(vac_pkg::KindFrame, 40'd4267);
    // bad frame, then a wall time earlier than it
    send_item(vac_pkg::KindFrame, 40'd10000);
    send_item(vac_pkg::KindFrame, 40'd9000);
    send_item(vac_pkg::KindFrame, 40'hAA_AAAA_AAAA);
  endtask

  task automatic test_register_sweep();
    set_regs(16'd4267, 16'd427, 20'd25600, 20'd25600, 16'd256);
    random_traffic(75);
    set_regs(16'd1000, 16'd100, 20'd5000, 20'd20000, 16'd50);
    random_traffic(75);
    set_regs(16'hFFFF, 16'hFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    random_traffic(75);
    set_regs(16'd0, 16'd0, 20'd0, 20'd0, 16'd0);
    random_traffic(60);
    set_regs(16'd1, 16'd0, 20'd0, 20'd0, 16'd0);
    random_traffic(60);
    for (int k = 0; k < 2; k++) begin
      set_regs(vac_pkg::PeriodW'($urandom_range(1, 65535)),
               vac_pkg::PeriodW'($urandom_range(0, 65535)),
               vac_pkg::ThreshW'($urandom_range(0, 1048575)),
               vac_pkg::ThreshW'($urandom_range(0, 1048575)),
               vac_pkg::PeriodW'($urandom_range(0, 65535)));
      random_traffic(60);
    end
  endtask

  task automatic test_output_stall();
    set_regs(16'd4267, 16'd427, 20'd25600, 20'd25600, 16'd256);
    tx_idle  = 1'b0;
    hold_req = 1'b1;
    random_traffic(40);
    tx_idle  = 1'b1;
  endtask

  task automatic test_back_to_back();
    set_regs(16'd2000, 16'd200, 20'd12000, 20'd15000, 16'd100);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_traffic(50);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= vac_pkg::KindStart;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= vac_pkg::RegVsyncPeriod;
    cfg_wdata_i   <= '0;
    error_cnt  = 0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    hold_req   = 1'b0;
    period_q   = 16'd4267;
    margin_q   = 16'd427;
    hard_q     = 20'd25600;
    window_q   = 20'd25600;
    step_q     = 16'd256;
    clock_q    = '0;
    mode_q     = vac_pkg::ModePredicted;
    last_bad_q = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_register_sweep();
    test_output_stall();
    test_back_to_back();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // output side: random stalls, one long hold on request
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      stall = rx_idle ? $urandom_range(0, 16) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    anim_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (anim_results_q.size() == 0) begin
        $display("%0t unexpected result: anim_time %0h", $realtime,
                 m_axis_tdata[vac_pkg::ClkW-1:0]);
        error_cnt++;
      end else begin
        want = anim_results_q.pop_front();
        if (m_axis_tdata[vac_pkg::ClkW-1:0] !== want.anim_time) begin
          $display("%0t anim_time exp %0h got %0h", $realtime, want.anim_time,
                   m_axis_tdata[vac_pkg::ClkW-1:0]);
          error_cnt++;
        end
        if (m_axis_tuser[0] !== want.time_mode) begin
          $display("%0t time_mode exp %0h got %0h", $realtime, want.time_mode,
                   m_axis_tuser[0]);
          error_cnt++;
        end
        if (m_axis_tuser[1] !== want.bad_frame) begin
          $display("%0t bad_frame exp %0h got %0h", $realtime, want.bad_frame,
                   m_axis_tuser[1]);
          error_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial cycle_cnt = 0;

endmodule
